@@ rtl/core/sutt_pkg.sv @@
// Package for the sorted unique key table: sizing constants, codes, types
// and small helper functions. Depends on nothing.

package sutt_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 16;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    key_t        key;
    logic [31:0] handle;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] handle;
    logic [4:0]  count;
    logic        empty;
  } result_t;

  // Only the low KEY_BITS bits of the key port take part in ordering.
  function automatic key_t key_of(input logic [15:0] z);
    logic [31:0] w;
    w = {16'b0, z};
    return w[KEY_BITS-1:0];
  endfunction

  // The reported entry count carries the low five bits of the count.
  function automatic logic [4:0] count5(input count_t c);
    logic [31:0] w;
    w = {{(32-COUNT_W){1'b0}}, c};
    return w[4:0];
  endfunction

endpackage

@@ rtl/core/sutt_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.

module sutt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/sutt_seq.sv @@
// Sequencer of the sorted unique key table: scans the entry RAM with one
// shared key comparator, shifts entries up and writes the new one.
// Depends on sutt_pkg.

module sutt_seq
  import sutt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              op,
  input  logic [15:0]       z_key,
  input  logic [31:0]       obj_handle,
  output logic              busy,
  output logic              ram_we,
  output logic [IDX_W-1:0]  ram_waddr,
  output entry_t            ram_wdata,
  output logic [IDX_W-1:0]  ram_raddr,
  input  entry_t            ram_rdata,
  output logic              done,
  output result_t           res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;

  localparam count_t CAP_C = COUNT_W'(CAPACITY);

  logic [2:0]  state, state_next;
  logic        op_q, op_next;
  key_t        key_q, key_next;
  logic [31:0] handle_q, handle_next;
  count_t      idx, idx_next;
  count_t      pos, pos_next;
  logic        hit, hit_next;
  logic [31:0] fh, fh_next;
  count_t      fill, fill_next;

  count_t      idx_inc, idx_dec, idx_dec2, fill_dec;
  logic        key_lt, key_eq;

  // The one shared comparator: stored key against the key being placed.
  assign key_lt = ram_rdata.key < key_q;
  assign key_eq = ram_rdata.key == key_q;

  assign idx_inc  = idx + 1'b1;
  assign idx_dec  = idx - 1'b1;
  assign idx_dec2 = idx - 2'd2;
  assign fill_dec = fill - 1'b1;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    op_next     = op_q;
    key_next    = key_q;
    handle_next = handle_q;
    idx_next    = idx;
    pos_next    = pos;
    hit_next    = hit;
    fh_next     = fh;
    fill_next   = fill;
    ram_we      = 1'b0;
    ram_waddr   = idx[IDX_W-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;
    done        = 1'b0;
    res.status  = ST_OK;
    res.found   = 1'b0;
    res.handle  = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          op_next     = op;
          key_next    = key_of(z_key);
          handle_next = obj_handle;
          idx_next    = '0;
          if (fill == '0) begin
            pos_next   = '0;
            hit_next   = 1'b0;
            state_next = S_DECIDE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (key_lt) begin
          if (idx_inc == fill) begin
            pos_next   = fill;
            hit_next   = 1'b0;
            state_next = S_DECIDE;
          end else begin
            idx_next  = idx_inc;
            ram_raddr = idx_inc[IDX_W-1:0];
          end
        end else begin
          pos_next   = idx;
          hit_next   = key_eq;
          fh_next    = ram_rdata.handle;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (op_q == OP_LOOKUP) begin
          done       = 1'b1;
          res.found  = hit;
          res.handle = hit ? fh : 32'd0;
          state_next = S_IDLE;
        end else if (hit) begin
          done       = 1'b1;
          res.status = ST_DUP;
          state_next = S_IDLE;
        end else if (fill == CAP_C) begin
          done       = 1'b1;
          res.status = ST_FULL;
          state_next = S_IDLE;
        end else begin
          idx_next = fill;
          if (fill == pos) begin
            state_next = S_WRITE;
          end else begin
            ram_raddr  = fill_dec[IDX_W-1:0];
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // The entry below slot idx arrived from the RAM; move it up one place.
        ram_we    = 1'b1;
        ram_waddr = idx[IDX_W-1:0];
        ram_wdata = ram_rdata;
        idx_next  = idx_dec;
        if (idx_dec == pos) begin
          state_next = S_WRITE;
        end else begin
          ram_raddr = idx_dec2[IDX_W-1:0];
        end
      end
      S_WRITE: begin
        ram_we           = 1'b1;
        ram_waddr        = pos[IDX_W-1:0];
        ram_wdata.key    = key_q;
        ram_wdata.handle = handle_q;
        fill_next        = fill + 1'b1;
        done             = 1'b1;
        state_next       = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.count = count5(fill_next);
    res.empty = (fill_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
    op_q     <= op_next;
    key_q    <= key_next;
    handle_q <= handle_next;
    idx      <= idx_next;
    pos      <= pos_next;
    hit      <= hit_next;
    fh       <= fh_next;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CAP_C)
    else $error("entry count exceeds capacity");

  a_fill_only_on_write: assert property (@(posedge clk) disable iff (rst)
    (state != S_WRITE) |=> $stable(fill))
    else $error("entry count changed outside the write step");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (idx > pos) && (idx <= fill))
    else $error("shift index outside the moving range");

  a_found_only_lookup: assert property (@(posedge clk) disable iff (rst)
    (done && res.found) |-> (op_q == OP_LOOKUP) && (res.status == ST_OK))
    else $error("match reported for an insert");

endmodule

@@ rtl/core/sorted_unique_key_table_top.sv @@
// Top level of the sorted unique key table: entry RAM, sequencer and the
// registered result word. Depends on sutt_pkg, sutt_ram and sutt_seq.
//
// The table keeps up to CAPACITY (key, handle) entries in ascending key
// order, with no two entries sharing a key. A command word is offered on
// op, z_key and obj_handle with start high; it is taken at a rising edge at
// which busy is low. op selects an insert of z_key with obj_handle or a
// lookup of z_key.
// Each command gives exactly one result word, shown for one cycle with done
// high: status, found, found_handle, entry_count and is_empty. The receiver
// cannot hold the result off, so it must take it in that cycle.
// A single key comparator walks the entries held, one per cycle, reading the
// entry RAM through its registered port; an insert then moves the later
// entries up one slot, one per cycle, through the same RAM port pair.
// The scan compares entries until it reaches the place of the key (none on
// an empty table), and an insert then moves the later entries up. A lookup
// or a refused insert ends after the scan, a successful insert after the
// shift and the write. busy falls in the cycle that done rises, so the next
// command can be taken then. The rate is therefore set by the scan and shift loops over the RAM.
// A synchronous reset empties the table at once (the entry count is
// cleared; stored entries are never read until rewritten), and the block is
// ready in the first cycle after reset.

module sorted_unique_key_table_top
  import sutt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [15:0] z_key,
  input  logic [31:0] obj_handle,
  output logic        done,
  output logic [1:0]  status,
  output logic        found,
  output logic [31:0] found_handle,
  output logic [4:0]  entry_count,
  output logic        is_empty
);

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic             seq_done;
  result_t          seq_res;
  result_t          res_q;

  sutt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sutt_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .z_key      (z_key),
    .obj_handle (obj_handle),
    .busy       (busy),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .done       (seq_done),
    .res        (seq_res)
  );

  // The result word is registered so that it leaves the block on a clean edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= seq_done;
    end
    if (seq_done) begin
      res_q <= seq_res;
    end
  end

  assign status       = res_q.status;
  assign found        = res_q.found;
  assign found_handle = res_q.handle;
  assign entry_count  = res_q.count;
  assign is_empty     = res_q.empty;

endmodule

@@ dv/sutt_checker.sv @@
// Checker for the sorted unique key table: watches the command and result
// words, predicts each result and compares it field by field.
// Depends on sutt_pkg for the sizing constants, codes and result type.

module sutt_checker
  import sutt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        op,
  input  logic [15:0] z_key,
  input  logic [31:0] obj_handle,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic        found,
  input  logic [31:0] found_handle,
  input  logic [4:0]  entry_count,
  input  logic        is_empty,
  output int          fail_count,
  output int          outstanding
);

  // Shadow copy of the table, kept in ascending key order.
  key_t        shadow_key [CAPACITY];
  logic [31:0] shadow_handle [CAPACITY];
  int          shadow_fill;

  // Results predicted for accepted commands, oldest first.
  result_t     awaited_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    shadow_fill = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR t=%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Applies one command to the shadow table and returns the result it gives.
  function automatic result_t apply_command(input logic cmd, input logic [15:0] z,
                                            input logic [31:0] h);
    key_t    k;
    int      slot;
    int      j;
    bit      hit;
    result_t r;
    k    = key_t'(z);
    slot = 0;
    while (slot < shadow_fill && shadow_key[slot] < k)
      slot++;
    hit = (slot < shadow_fill) && (shadow_key[slot] == k);
    r = '0;
    r.status = ST_OK;
    if (cmd == OP_INSERT) begin
      if (hit) begin
        r.status = ST_DUP;
      end else if (shadow_fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (j = shadow_fill; j > slot; j--) begin
          shadow_key[j]    = shadow_key[j-1];
          shadow_handle[j] = shadow_handle[j-1];
        end
        shadow_key[slot]    = k;
        shadow_handle[slot] = h;
        shadow_fill++;
      end
    end else if (hit) begin
      r.found  = 1'b1;
      r.handle = shadow_handle[slot];
    end
    r.count = 5'(shadow_fill);
    r.empty = (shadow_fill == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      shadow_fill = 0;
      awaited_results.delete();
    end else begin
      // A result leaves before a new command is predicted: both may share an edge.
      if (done !== 1'b0) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with no command waiting");
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(status), 32'(want.status));
          check_field("found", 32'(found), 32'(want.found));
          check_field("found_handle", found_handle, want.handle);
          check_field("entry_count", 32'(entry_count), 32'(want.count));
          check_field("is_empty", 32'(is_empty), 32'(want.empty));
        end
      end
      if (start && !busy)
        awaited_results.push_back(apply_command(op, z_key, obj_handle));
    end
    outstanding <= awaited_results.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the sorted unique key table testbench: clock, reset, command
// stimulus and the verdict. Depends on sutt_pkg, sutt_checker and the RTL.

module testbench
  import sutt_pkg::*;
();

  localparam int RANDOM_WORDS  = 800;
  // The limit leaves a wide margin over the slowest command plus the longest
  // sender gap for every word, so it is already pessimistic.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        op;
  logic [15:0] z_key;
  logic [31:0] obj_handle;
  logic        done;
  logic [1:0]  status;
  logic        found;
  logic [31:0] found_handle;
  logic [4:0]  entry_count;
  logic        is_empty;

  int          fail_count;
  int          outstanding;
  int          cycle_count;
  bit          gaps_enabled;

  // Keys known to sit in the table, so that lookups and duplicate inserts
  // can aim at them.
  logic [15:0] stored_keys [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_unique_key_table_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .z_key        (z_key),
    .obj_handle   (obj_handle),
    .done         (done),
    .status       (status),
    .found        (found),
    .found_handle (found_handle),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
  );

  sutt_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .z_key        (z_key),
    .obj_handle   (obj_handle),
    .done         (done),
    .status       (status),
    .found        (found),
    .found_handle (found_handle),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // Offers one command word and returns at the edge that takes it. start is
  // left high, so back-to-back words keep it high without a glitch; the
  // next call lowers it only if it decides to idle first. Idle gaps are long
  // enough to end in any phase of the scan and shift.
  // While idle, the fields carry junk that the block must ignore.
  task automatic send_word(input logic cmd, input logic [15:0] z,
                           input logic [31:0] h);
    int gap;
    gap = 0;
    if (gaps_enabled && $urandom_range(99) < 26)
      gap = $urandom_range(1, 24);
    repeat (gap) begin
      start      <= 1'b0;
      op         <= 1'($urandom);
      z_key      <= 16'($urandom);
      obj_handle <= $urandom;
      @(posedge clk);
    end
    start      <= 1'b1;
    op         <= cmd;
    z_key      <= z;
    obj_handle <= h;
    do @(posedge clk); while (busy);
  endtask

  // Holds the sender off until every predicted result has come back, within
  // a bound, so a hung block still reaches the verdict.
  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
  endtask

  // Watchdog: a block that stops answering ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int          pick;
    int          i;
    logic [15:0] k;
    rst          = 1'b1;
    start        = 1'b0;
    op           = OP_INSERT;
    z_key        = '0;
    obj_handle   = '0;
    gaps_enabled = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A lookup on the empty table, then both key extremes
    // with the all-ones and the zero handle, a duplicate, a hit on the zero
    // handle and a miss.
    send_word(OP_LOOKUP, 16'h1234, 32'hDEAD_BEEF);
    send_word(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 16'h0000, 32'h0000_0000);
    send_word(OP_INSERT, 16'h8000, 32'hA5A5_5A5A);
    send_word(OP_INSERT, 16'hFFFF, 32'h0000_0001);
    send_word(OP_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
    send_word(OP_LOOKUP, 16'hFFFF, 32'h0000_0000);
    send_word(OP_LOOKUP, 16'h7FFF, 32'h1234_5678);
    stored_keys = '{16'hFFFF, 16'h0000, 16'h8000};

    // Fill the remaining thirteen slots. The keys come in a scrambled order
    // so that the inserts land at places spread over the middle of the table
    // rather than always at one end.
    for (i = 0; i < 13; i++) begin
      k = 16'h0100 * 16'((i * 5) % 13 + 1);
      stored_keys.push_back(k);
      send_word(OP_INSERT, k, $urandom);
    end

    // Table full: a fresh key is refused as full, while a duplicate still
    // reports the duplicate first.
    send_word(OP_INSERT, 16'h4321, 32'h0BAD_F00D);
    send_word(OP_INSERT, 16'h8000, 32'h0BAD_F00D);
    send_word(OP_LOOKUP, 16'h8000, 32'h0000_0000);

    // Let the directed words finish before the random part starts.
    drain_results();

    // Random part. Most words aim at stored keys, as hits and duplicate
    // inserts; the rest are fresh keys, which the full table refuses or
    // which miss. A stretch in the middle runs with no gaps at all.
    for (i = 0; i < RANDOM_WORDS; i++) begin
      gaps_enabled = !(i >= 300 && i < 500);
      if (i == 600)
        drain_results();
      pick = $urandom_range(99);
      k = 16'($urandom);
      if (pick < 5)
        k = (pick < 2) ? 16'h0000 : 16'hFFFF;
      else if (pick < 55)
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      if (pick < 40 || pick >= 80)
        send_word(OP_LOOKUP, k, $urandom);
      else
        send_word(OP_INSERT, k, $urandom);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (outstanding != 0)
      $display("ERROR: %0d result words never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
